>>> rtl/lva_pkg.sv
// lva_pkg: shared constants and types of the lru voice allocator
// used by the interfaces, the list cell and the top level
`default_nettype none

package lva_pkg;

    localparam int VOICE_COUNT_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int NOTE_W          = 7;
    localparam int DRIVE_IDX_W     = 3;

    // midi status codes, compared after masking the channel nibble
    localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_NOTE_OFF = 8'h80;
    localparam logic [BYTE_W-1:0] ST_NOTE_ON  = 8'h90;
    localparam logic [BYTE_W-1:0] DATA_MASK   = 8'h7F;

    // broadcast from the top level to every list cell
    typedef struct packed {
        logic              note_on;
        logic [NOTE_W-1:0] note;
    } t_ctrl;

endpackage

`default_nettype wire

>>> rtl/lva_if.sv
// lva_midi_if and lva_voice_if: valid/ready channels of the allocator
// depends on lva_pkg for field widths
`default_nettype none

interface lva_midi_if import lva_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] note_byte;
    logic [BYTE_W-1:0] velocity_byte;

    modport source (output valid, output status_byte, output note_byte,
                    output velocity_byte, input ready);
    modport sink   (input valid, input status_byte, input note_byte,
                    input velocity_byte, output ready);
endinterface

interface lva_voice_if import lva_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [DRIVE_IDX_W-1:0] drive_index;
    logic [NOTE_W-1:0]      drive_note;

    modport source (output valid, output drive_index, output drive_note, input ready);
    modport sink   (input valid, input drive_index, input drive_note, output ready);
endinterface

`default_nettype wire

>>> rtl/lva_cell.sv
// lva_cell: one position of the drive order list (drive id and its note)
// depends on lva_pkg; chained by lru_voice_allocator
`default_nettype none

module lva_cell import lva_pkg::*; #(
    parameter int ID_W     = 3,
    parameter int CELL_IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl             i_ctrl,
    input  wire logic              i_commit,
    input  wire logic              i_found,
    input  wire logic [ID_W-1:0]   i_sel_id,
    input  wire logic [ID_W-1:0]   i_nb_id,
    input  wire logic [NOTE_W-1:0] i_nb_note,
    output logic                   o_found,
    output logic [ID_W-1:0]        o_sel_id,
    output logic [ID_W-1:0]        o_id,
    output logic [NOTE_W-1:0]      o_note
);

    logic [ID_W-1:0]   r_id;
    logic [NOTE_W-1:0] r_note;
    logic              match;
    logic              hit;

    // note-on takes the front entry, so every cell matches and the first wins
    assign match    = i_ctrl.note_on || (r_note == i_ctrl.note);
    assign hit      = match && !i_found;
    assign o_found  = i_found || match;
    assign o_sel_id = hit ? r_id : i_sel_id;
    assign o_id     = r_id;
    assign o_note   = r_note;

    // cells at and behind the hit take their neighbor's entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id   <= ID_W'(CELL_IDX);
            r_note <= '0;
        end else if (i_commit && o_found) begin
            r_id   <= i_nb_id;
            r_note <= i_nb_note;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lru_voice_allocator.sv
// lru_voice_allocator: top level, request decode, cell chain and result register
// depends on lva_pkg, lva_if and lva_cell
// flow: an accepted request waits in the request registers until the lookup step
//   fires, which is held off while an untaken result fills the result register;
//   no new request is taken while one is pending in the register stage in front
//   of the single match and shift step of the cell chain
// reset: list returns to drive i at position i with every drive idle
`default_nettype none

module lru_voice_allocator import lva_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lva_midi_if.sink     i_midi,
    lva_voice_if.source  o_voice
);

    localparam int ID_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    logic              r_busy;
    logic              r_search;
    logic              r_note_on;
    logic [NOTE_W-1:0] r_note;
    logic              r_out_valid;
    logic [DRIVE_IDX_W-1:0] r_out_idx;
    logic [NOTE_W-1:0] r_out_note;

    logic [BYTE_W-1:0] status;
    logic [NOTE_W-1:0] vel;
    logic              accept;
    logic              fire;
    logic              commit;
    logic [NOTE_W-1:0] n_tail_note;
    t_ctrl             ctrl;

    logic              found   [VOICE_COUNT+1];
    logic [ID_W-1:0]   sel_id  [VOICE_COUNT+1];
    logic [ID_W-1:0]   cell_id   [VOICE_COUNT];
    logic [NOTE_W-1:0] cell_note [VOICE_COUNT];
    logic [ID_W-1:0]   nb_id     [VOICE_COUNT];
    logic [NOTE_W-1:0] nb_note   [VOICE_COUNT];

    assign status = i_midi.status_byte & STATUS_MASK;
    assign vel    = NOTE_W'(i_midi.velocity_byte & DATA_MASK);

    assign i_midi.ready = !r_busy;
    assign accept       = i_midi.valid && !r_busy;

    // lookup step runs once the result slot is free or being emptied
    assign fire        = r_busy && (!r_out_valid || o_voice.ready);
    assign commit      = fire && r_search && found[VOICE_COUNT];
    assign n_tail_note = r_note_on ? r_note : '0;

    assign ctrl.note_on = r_note_on;
    assign ctrl.note    = r_note;

    assign found[0]  = 1'b0;
    assign sel_id[0] = '0;

    for (genvar k = 0; k < VOICE_COUNT; k++) begin : g_cell
        if (k == VOICE_COUNT - 1) begin : g_tail
            // the selected drive re-enters at the back of the list
            assign nb_id[k]   = sel_id[VOICE_COUNT];
            assign nb_note[k] = n_tail_note;
        end else begin : g_body
            assign nb_id[k]   = cell_id[k+1];
            assign nb_note[k] = cell_note[k+1];
        end

        lva_cell #(
            .ID_W     (ID_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_commit  (commit),
            .i_found   (found[k]),
            .i_sel_id  (sel_id[k]),
            .i_nb_id   (nb_id[k]),
            .i_nb_note (nb_note[k]),
            .o_found   (found[k+1]),
            .o_sel_id  (sel_id[k+1]),
            .o_id      (cell_id[k]),
            .o_note    (cell_note[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= commit;
            end else if (o_voice.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_note    <= NOTE_W'(i_midi.note_byte & DATA_MASK);
            r_note_on <= (status == ST_NOTE_ON) && (vel != '0);
            r_search  <= (status == ST_NOTE_ON) || (status == ST_NOTE_OFF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_idx  <= DRIVE_IDX_W'(sel_id[VOICE_COUNT]);
            r_out_note <= n_tail_note;
        end
    end

    assign o_voice.valid       = r_out_valid;
    assign o_voice.drive_index = r_out_idx;
    assign o_voice.drive_note  = r_out_note;

`ifndef ASSERT_OFF
    a_note_on_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_note_on |-> r_search && found[VOICE_COUNT])
        else $error("note-on found no drive");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_voice.valid && (o_voice.drive_note == $past(n_tail_note)))
        else $error("committed lookup gave no result");

    a_busy_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !accept |=> !r_busy || $past(r_out_valid && !o_voice.ready))
        else $error("lookup held without a stalled result");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy && !i_midi.ready)
        else $error("request taken while lookup pending");
`endif

endmodule

`default_nettype wire

>>> tb/lru_voice_allocator_tb.sv
`timescale 1ns / 100ps
// lru_voice_allocator_tb: directed and random midi traffic against a voice list predictor
// depends on lva_pkg, lva_if and the lru_voice_allocator rtl

module lru_voice_allocator_tb;
    import lva_pkg::*;

    localparam int N_DRIVES    = VOICE_COUNT_DEF;
    localparam int STALL_MAX   = 11;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 6;

    typedef struct packed {
        logic [DRIVE_IDX_W-1:0] drive;
        logic [NOTE_W-1:0]      note;
    } t_voice_cmd;

    logic clk;
    logic rst_n;

    lva_midi_if  midi_if ();
    lva_voice_if voice_if ();

    lru_voice_allocator #(.VOICE_COUNT(N_DRIVES)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_midi  (midi_if),
        .o_voice (voice_if)
    );

    // predicted voice list, least recently assigned first
    int                drive_order [N_DRIVES];
    logic [NOTE_W-1:0] note_order  [N_DRIVES];
    t_voice_cmd        pending_cmds [$];

    int error_count  = 0;
    int quiet_cycles = 0;
    int hold_len     = 0;
    bit idle_on      = 1'b1;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void reset_allocation();
        for (int i = 0; i < N_DRIVES; i++) begin
            drive_order[i] = i;
            note_order[i]  = '0;
        end
    endfunction

    function automatic void move_to_back(int pos, logic [NOTE_W-1:0] new_note);
        int id;
        id = drive_order[pos];
        for (int k = pos; k < N_DRIVES - 1; k++) begin
            drive_order[k] = drive_order[k + 1];
            note_order[k]  = note_order[k + 1];
        end
        drive_order[N_DRIVES - 1] = id;
        note_order[N_DRIVES - 1]  = new_note;
    endfunction

    function automatic void allocate_voice(logic [BYTE_W-1:0] st, logic [BYTE_W-1:0] nt,
                                           logic [BYTE_W-1:0] vl);
        logic [BYTE_W-1:0] status;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
        t_voice_cmd        cmd;
        int                hit;
        status = st & STATUS_MASK;
        note   = NOTE_W'(nt & DATA_MASK);
        vel    = NOTE_W'(vl & DATA_MASK);
        hit    = -1;
        if (status == ST_NOTE_ON && vel != 0) begin
            cmd.drive = DRIVE_IDX_W'(drive_order[0]);
            cmd.note  = note;
            move_to_back(0, note);
            pending_cmds = {pending_cmds, cmd};
        end else if (status == ST_NOTE_OFF || status == ST_NOTE_ON) begin
            // idle drives hold note zero, so a release of note zero frees the first idle one
            for (int i = 0; i < N_DRIVES; i++) begin
                if (hit < 0 && note_order[i] == note) hit = i;
            end
            if (hit >= 0) begin
                cmd.drive = DRIVE_IDX_W'(drive_order[hit]);
                cmd.note  = '0;
                move_to_back(hit, '0);
                pending_cmds = {pending_cmds, cmd};
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_voice_cmd(input logic [DRIVE_IDX_W-1:0] drv,
                                   input logic [NOTE_W-1:0] nt);
        t_voice_cmd want;
        if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command drive %0d note %0d", drv, nt));
            return;
        end
        want = pending_cmds.pop_front();
        if (drv !== want.drive)
            report_mismatch($sformatf("drive_index %0d, wanted %0d", drv, want.drive));
        if (nt !== want.note)
            report_mismatch($sformatf("drive_note %0d, wanted %0d", nt, want.note));
    endtask

    // valid stays high on return when no gap follows, so a back-to-back request needs no second assignment
    task automatic send_request(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] nt,
                                input logic [BYTE_W-1:0] vl);
        int gap;
        midi_if.valid         <= 1'b1;
        midi_if.status_byte   <= st;
        midi_if.note_byte     <= nt;
        midi_if.velocity_byte <= vl;
        do @(posedge clk); while (midi_if.ready !== 1'b1);
        allocate_voice(st, nt, vl);
        gap = idle_on ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            midi_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        midi_if.valid <= 1'b0;
        do @(posedge clk); while (pending_cmds.size() != 0);
    endtask

    task automatic send_random_request(output bit counted);
        logic [BYTE_W-1:0] st;
        logic [BYTE_W-1:0] nt;
        logic [BYTE_W-1:0] vl;
        logic [3:0]        chan;
        int                pick;
        chan = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        nt   = 8'($urandom_range(0, 255));
        vl   = 8'($urandom_range(0, 255));
        if (pick < 45) begin
            st = ST_NOTE_ON | chan;
            // a narrow note pool makes repeated notes and releases collide often
            if ($urandom_range(0, 3) != 0) nt[NOTE_W-1:0] = 7'($urandom_range(36, 47));
            if (vl[NOTE_W-1:0] == '0) vl[0] = 1'b1;
        end else if (pick < 80) begin
            nt[NOTE_W-1:0] = note_order[$urandom_range(0, N_DRIVES - 1)];
            if ($urandom_range(0, 1) == 0) begin
                st = ST_NOTE_OFF | chan;
            end else begin
                st = ST_NOTE_ON | chan;
                vl[NOTE_W-1:0] = '0;
            end
        end else if (pick < 90) begin
            st = ST_NOTE_OFF | chan;
        end else begin
            st = 8'($urandom_range(0, 255));
        end
        counted = ((st & STATUS_MASK) == ST_NOTE_OFF) || ((st & STATUS_MASK) == ST_NOTE_ON);
        send_request(st, nt, vl);
    endtask

    task automatic test_ignored_status();
        send_request(8'h00, 8'h00, 8'h00);
        send_request(8'hFF, 8'hFF, 8'hFF);
        send_request(8'hA5, 8'h3C, 8'h40);
        send_request(8'hF0, 8'h00, 8'h7F);
        wait_for_drain();
    endtask

    task automatic test_note_off_cases();
        send_request(ST_NOTE_OFF, 8'h3C, 8'h40);          // nothing plays the note
        send_request(ST_NOTE_OFF | 8'h0F, 8'h80, 8'h7F);  // note zero frees an idle drive
        send_request(ST_NOTE_ON, 8'h00, 8'h00);           // velocity zero releases too
        wait_for_drain();
    endtask

    task automatic test_note_on_extremes();
        send_request(ST_NOTE_ON, 8'hFF, 8'hFF);
        send_request(ST_NOTE_ON | 8'h0F, 8'h00, 8'h01);
        send_request(ST_NOTE_ON | 8'h05, 8'h7F, 8'h80);   // masked velocity is zero
        send_request(ST_NOTE_ON, 8'h01, 8'h7F);
        wait_for_drain();
    endtask

    task automatic test_voice_stealing();
        // more notes than drives so the oldest drives get reassigned
        for (int i = 0; i < 10; i++)
            send_request(ST_NOTE_ON | 8'(i), 8'(60 + i), 8'(8'h40 + i));
        send_request(ST_NOTE_OFF, 8'd60, 8'h40);
        send_request(ST_NOTE_OFF | 8'h02, 8'd69, 8'h00);
        send_request(ST_NOTE_ON | 8'h03, 8'd68, 8'h00);
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        bit counted;
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) send_random_request(counted);
        wait_for_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_items, input bit idling);
        int done;
        bit counted;
        idle_on = idling;
        done    = 0;
        while (done < n_items) begin
            send_random_request(counted);
            if (counted) begin
                done++;
                if (done % 100 == 0) wait_for_drain();
            end
        end
        wait_for_drain();
    endtask

    // result side: random stalls, plus a long hold-off when a test asks for one
    initial begin
        int stall;
        voice_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_len > 0) begin
                voice_if.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, STALL_MAX) : 0;
                if (stall > 0) begin
                    voice_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                voice_if.ready <= 1'b1;
                do @(posedge clk); while (voice_if.valid !== 1'b1 && hold_len == 0);
                if (voice_if.valid === 1'b1)
                    check_voice_cmd(voice_if.drive_index, voice_if.drive_note);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((midi_if.valid === 1'b1 && midi_if.ready === 1'b1) ||
                (voice_if.valid === 1'b1 && voice_if.ready === 1'b1))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[lru_voice_allocator] ERROR");
                $finish;
            end
        end
    end

    initial begin
        rst_n                 <= 1'b0;
        midi_if.valid         <= 1'b0;
        midi_if.status_byte   <= '0;
        midi_if.note_byte     <= '0;
        midi_if.velocity_byte <= '0;
        reset_allocation();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_ignored_status();
        test_note_off_cases();
        test_note_on_extremes();
        test_voice_stealing();
        test_backpressure();
        test_random_traffic(260, 1'b1);
        test_random_traffic(100, 1'b0);
        test_random_traffic(260, 1'b1);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[lru_voice_allocator] OK");
        else
            $display("[lru_voice_allocator] ERROR");
        $finish;
    end

endmodule
